[rtl/core/bsfr_pkg.sv]
// ----------------------------------------------------------------------------
// bsfr_pkg
// Types and constants shared by the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfr_pkg;

  localparam logic [7:0] FLAG_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_BYTE   = 8'h7E;
  localparam logic [7:0] ESC_OFFSET = 8'h20;

  // command codes
  localparam logic CMD_RAW = 1'b0;
  localparam logic CMD_END = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] raw_byte;
  } bsfr_in_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic       frame_good;
  } bsfr_out_t;

endpackage

`default_nettype wire

[rtl/core/bsfr_in_stage.sv]
// ----------------------------------------------------------------------------
// bsfr_in_stage
// Input register; holds one item until the deframer consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfr_in_stage
  import bsfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire bsfr_in_t in_data,
  input  wire logic     advance,
  output logic          item_valid,
  output bsfr_in_t      item
);

  logic     valid_r;
  bsfr_in_t data_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bsfr_deframe.sv]
// ----------------------------------------------------------------------------
// bsfr_deframe
// Frame state, one-byte hold, unescape and running checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfr_deframe
  import bsfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire bsfr_in_t item,
  input  wire logic     step,
  output logic          has_res,
  output bsfr_out_t     res
);

  logic       inside_r, inside_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_raw_r, held_raw_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       is_flag;

  assign is_flag = (item.cmd == CMD_RAW) && (item.raw_byte == FLAG_BYTE);

  always_comb begin
    inside_nxt     = inside_r;
    held_valid_nxt = held_valid_r;
    held_raw_nxt   = held_raw_r;
    esc_nxt        = esc_r;
    sum_nxt        = sum_r;
    has_res        = 1'b0;
    res            = '0;
    if (!inside_r) begin
      if (is_flag) begin
        inside_nxt     = 1'b1;
        held_valid_nxt = 1'b0;
        held_raw_nxt   = 8'h00;
        esc_nxt        = 1'b0;
        sum_nxt        = 8'h00;
      end
    end else if (item.cmd == CMD_END || is_flag) begin
      has_res        = 1'b1;
      res.frame_end  = 1'b1;
      res.frame_good = held_valid_r && !esc_r && (held_raw_r == sum_r);
      // a closing flag reopens; end of burst returns to hunting
      inside_nxt     = is_flag;
      held_valid_nxt = 1'b0;
      held_raw_nxt   = 8'h00;
      esc_nxt        = 1'b0;
      sum_nxt        = 8'h00;
    end else begin
      if (held_valid_r) begin
        sum_nxt = sum_r + held_raw_r;
        if (esc_r) begin
          esc_nxt          = 1'b0;
          has_res          = 1'b1;
          res.data_valid   = 1'b1;
          res.payload_byte = held_raw_r + ESC_OFFSET;
        end else if (held_raw_r == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else begin
          has_res          = 1'b1;
          res.data_valid   = 1'b1;
          res.payload_byte = held_raw_r;
        end
      end
      held_raw_nxt   = item.raw_byte;
      held_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r     <= 1'b0;
      held_valid_r <= 1'b0;
      held_raw_r   <= 8'h00;
      esc_r        <= 1'b0;
      sum_r        <= 8'h00;
    end else if (step) begin
      inside_r     <= inside_nxt;
      held_valid_r <= held_valid_nxt;
      held_raw_r   <= held_raw_nxt;
      esc_r        <= esc_nxt;
      sum_r        <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/byte_stuffed_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_top
// Deframer for 0x7D-flagged, 0x7E-escaped byte frames with sum checksum.
// ----------------------------------------------------------------------------
// One raw byte or end-of-burst command per item, one item per clock
// sustained. An item goes into an input register, is deframed from there
// and its result (payload byte or frame status) lands in the output
// register, which drives out_valid. Payload bytes trail the line by one
// raw byte, since the held byte may be the checksum. The input register
// keeps taking items while a result waits at the output; only items that
// produce a result stall behind it.
`default_nettype none

module byte_stuffed_frame_receiver_top
  import bsfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire bsfr_in_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output bsfr_out_t     out_data
);

  logic      item_valid;
  bsfr_in_t  item;
  logic      advance;
  logic      has_res;
  bsfr_out_t res;
  logic      out_valid_r;
  bsfr_out_t out_data_r;

  // a result-free item never waits on the output register
  assign advance = item_valid && (!has_res || !out_valid_r || out_ready);

  bsfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bsfr_deframe u_deframe (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .step    (advance),
    .has_res (has_res),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_res) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[bench/byte_stuffed_frame_receiver_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_checker
// Watches both channels of the deframer, predicts each result item from the
// accepted line items and compares every accepted result field by field.
// ----------------------------------------------------------------------------

module byte_stuffed_frame_receiver_checker
  import bsfr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire bsfr_in_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire bsfr_out_t out_data,
  output int             fail_count,
  output int             pending_count,
  output int             frames_closed,
  output int             good_frames,
  output int             payload_count
);

  // deframer mirror
  logic       frm_open;
  logic       hold_vld;
  logic [7:0] hold_byte;
  logic       esc_wait;
  logic [7:0] csum;

  bsfr_out_t deframed_q[$];
  bsfr_out_t want;

  task automatic clear_frame();
    hold_vld  = 1'b0;
    hold_byte = '0;
    esc_wait  = 1'b0;
    csum      = '0;
  endtask

  task automatic deframe_step(input bsfr_in_t item);
    bsfr_out_t res;
    res = '0;
    if (!frm_open) begin
      if (item.cmd == CMD_RAW && item.raw_byte == FLAG_BYTE) begin
        frm_open = 1'b1;
        clear_frame();
      end
    end else if (item.cmd == CMD_END || item.raw_byte == FLAG_BYTE) begin
      res.frame_end  = 1'b1;
      res.frame_good = hold_vld && !esc_wait && (hold_byte == csum);
      deframed_q.push_back(res);
      // a flag closes and reopens, end of burst goes back to hunting
      frm_open = (item.cmd == CMD_RAW);
      clear_frame();
    end else begin
      if (hold_vld) begin
        csum = csum + hold_byte;
        if (esc_wait) begin
          esc_wait         = 1'b0;
          res.data_valid   = 1'b1;
          res.payload_byte = hold_byte + ESC_OFFSET;
          deframed_q.push_back(res);
        end else if (hold_byte == ESC_BYTE) begin
          esc_wait = 1'b1;
        end else begin
          res.data_valid   = 1'b1;
          res.payload_byte = hold_byte;
          deframed_q.push_back(res);
        end
      end
      hold_byte = item.raw_byte;
      hold_vld  = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s expected %0h got %0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frm_open = 1'b0;
      clear_frame();
      deframed_q.delete();
      pending_count = 0;
    end else begin
      if (in_valid && in_ready) deframe_step(in_data);
      if (out_valid && out_ready) begin
        if (deframed_q.size() == 0) begin
          $error("unexpected result item %p", out_data);
          fail_count++;
        end else begin
          want = deframed_q.pop_front();
          check_field("data_valid", int'(want.data_valid), int'(out_data.data_valid));
          check_field("payload_byte", int'(want.payload_byte),
                      int'(out_data.payload_byte));
          check_field("frame_end", int'(want.frame_end), int'(out_data.frame_end));
          check_field("frame_good", int'(want.frame_good), int'(out_data.frame_good));
          if (want.frame_end) begin
            frames_closed++;
            if (want.frame_good) good_frames++;
          end
          if (want.data_valid) payload_count++;
        end
      end
      pending_count = deframed_q.size();
    end
  end

endmodule

[bench/tb_byte_stuffed_frame_receiver_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_stuffed_frame_receiver_top
// Drives line bytes and end-of-burst items into the deframer: a directed
// set of corner frames, then random well-formed, corrupted and noisy
// traffic with random gaps and output stalls. The checker scores results.
// ----------------------------------------------------------------------------

module tb_byte_stuffed_frame_receiver_top;
  import bsfr_pkg::*;

  localparam int ITEM_TARGET = 2000;
  localparam int QUIET_TAIL  = 150;
  localparam int HOLD_AT     = 800;
  localparam int HOLD_LEN    = 500;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  bsfr_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  bsfr_out_t out_data;

  int fail_count;
  int pending_count;
  int frames_closed;
  int good_frames;
  int payload_count;

  int   items_sent = 0;
  int   in_gap_pct = 20;
  logic quiet      = 1'b0;
  logic fresh      = 1'b0;  // last item was a flag, a new frame is open and empty

  byte_stuffed_frame_receiver_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  byte_stuffed_frame_receiver_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .frames_closed(frames_closed),
    .good_frames  (good_frames),
    .payload_count(payload_count)
  );

  always #10 clk = ~clk;

  task automatic send_item(input logic cmd, input logic [7:0] raw);
    bsfr_in_t item;
    item.cmd      = cmd;
    item.raw_byte = raw;
    if (!quiet && in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fresh = (cmd == CMD_RAW && raw == FLAG_BYTE);
    items_sent++;
    quiet = (items_sent >= ITEM_TARGET - QUIET_TAIL);
  endtask

  // one frame of random payload, stuffed, with a mostly correct checksum
  task automatic send_frame();
    int         len;
    int         kind;
    logic [7:0] b;
    logic [7:0] esc_b;
    logic [7:0] sum;
    logic [7:0] flip;
    if (!fresh) send_item(CMD_RAW, FLAG_BYTE);
    sum = '0;
    len = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      case ($urandom_range(7))
        0: b = FLAG_BYTE;
        1: b = ESC_BYTE;
        default: ;
      endcase
      esc_b = b - ESC_OFFSET;
      // 0x9D cannot be escaped, its stuffed form would be a flag
      if (b == FLAG_BYTE || b == ESC_BYTE || (b != 8'h9D && $urandom_range(7) == 0)) begin
        send_item(CMD_RAW, ESC_BYTE);
        send_item(CMD_RAW, esc_b);
        sum = sum + ESC_BYTE + esc_b;
      end else begin
        send_item(CMD_RAW, b);
        sum = sum + b;
      end
    end
    kind = $urandom_range(19);
    if (kind == 0) begin
      flip = 8'($urandom_range(1, 255));
      send_item(CMD_RAW, sum ^ flip);
    end else if (kind == 1) begin
      // escape left hanging at the close
      b = 8'($urandom_range(0, 255));
      if (b == FLAG_BYTE) b = 8'h00;
      send_item(CMD_RAW, ESC_BYTE);
      send_item(CMD_RAW, b);
    end else if (kind != 2) begin
      send_item(CMD_RAW, sum);
    end
    if ($urandom_range(1) == 0) send_item(CMD_RAW, FLAG_BYTE);
    else send_item(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ignored bytes and an end of burst while hunting
    send_item(CMD_RAW, 8'h00);
    send_item(CMD_RAW, 8'hFF);
    send_item(CMD_END, 8'hFF);
    // empty frame
    send_item(CMD_RAW, FLAG_BYTE);
    send_item(CMD_RAW, FLAG_BYTE);
    // good frame closed by a flag
    send_item(CMD_RAW, 8'h01);
    send_item(CMD_RAW, 8'h02);
    send_item(CMD_RAW, 8'h03);
    send_item(CMD_RAW, FLAG_BYTE);
    // escaped flag, escaped 0x9E, 0xFF; closed by end of burst
    send_item(CMD_RAW, ESC_BYTE);
    send_item(CMD_RAW, 8'h5D);
    send_item(CMD_RAW, ESC_BYTE);
    send_item(CMD_RAW, ESC_BYTE);
    send_item(CMD_RAW, 8'hFF);
    send_item(CMD_RAW, 8'hD6);
    send_item(CMD_END, 8'h00);
    // escape pending at the close
    send_item(CMD_RAW, FLAG_BYTE);
    send_item(CMD_RAW, 8'h00);
    send_item(CMD_RAW, ESC_BYTE);
    send_item(CMD_RAW, 8'h00);
    send_item(CMD_END, FLAG_BYTE);
    // wrong checksum, then an empty frame closed by end of burst
    send_item(CMD_RAW, FLAG_BYTE);
    send_item(CMD_RAW, 8'h80);
    send_item(CMD_RAW, 8'h00);
    send_item(CMD_RAW, FLAG_BYTE);
    send_item(CMD_END, 8'h00);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(3))
        0: in_gap_pct = 0;
        1: in_gap_pct = 5;
        2: in_gap_pct = 20;
        default: in_gap_pct = 50;
      endcase
      if ($urandom_range(4) == 0) begin
        // line noise: stray bytes, stray flags, stray ends
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(3) == 0) send_item(CMD_END, 8'($urandom_range(0, 255)));
          else if ($urandom_range(5) == 0) send_item(CMD_RAW, FLAG_BYTE);
          else send_item(CMD_RAW, 8'($urandom_range(0, 255)));
        end
      end else begin
        send_frame();
      end
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d line items incl. corner frames and noise, one long output hold-off.",
             items_sent);
    $display("Checked %0d frame closes (%0d good) and %0d payload bytes.",
             frames_closed, good_frames, payload_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver side: random stalls, one long hold-off, none at the tail
  initial begin
    int  cyc;
    int  len;
    logic held;
    cyc  = 0;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (!held && cyc >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        cyc += HOLD_LEN;
        held = 1'b1;
      end else begin
        len = $urandom_range(1, 40);
        out_ready <= 1'b1;
        repeat (len) @(posedge clk);
        cyc += len;
        if ($urandom_range(2) != 0 && !quiet) begin
          len = $urandom_range(1, 19);
          out_ready <= 1'b0;
          repeat (len) @(posedge clk);
          cyc += len;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
